[rtl/rpgt_pkg.sv]
// Package for the portmap GETPORT tracker: parse phases, status codes,
// register indexes and the front-to-back record. No dependencies.
package rpgt_pkg;

	localparam int unsigned SessionsDefault = 16;
	localparam int unsigned MaxWordsDefault = 64;
	localparam int unsigned SlotsDefault    = 6;
	localparam int unsigned NumSlotRegs     = 6;
	localparam int unsigned MinWords        = 7;
	localparam int unsigned QueueDepth      = 4;

	localparam logic [31:0] RpcVers     = 32'd2;
	localparam logic [31:0] PmapProgram = 32'd100000;
	localparam logic [31:0] ProcGetport = 32'd3;
	localparam logic [31:0] PortLimit   = 32'd65535;

	localparam logic [31:0] SlotReset [NumSlotRegs] = '{
		32'd100000, 32'd100003, 32'd100005, 32'd100021, 32'd100227, 32'd0
	};

	localparam logic [2:0] RegSlot0 = 3'd0;

	typedef enum logic [10:0] {
		PH_IDLE   = 11'b00000000001,
		PH_HEAD   = 11'b00000000010,
		PH_CFIX   = 11'b00000000100,
		PH_CSKIP1 = 11'b00000001000,
		PH_CVLEN  = 11'b00000010000,
		PH_CSKIP2 = 11'b00000100000,
		PH_RFIX   = 11'b00001000000,
		PH_RSKIP  = 11'b00010000000,
		PH_RPORT  = 11'b00100000000,
		PH_DONE   = 11'b01000000000,
		PH_STOP   = 11'b10000000000
	} phase_t;

	typedef enum logic [2:0] {
		ST_SHORT    = 3'd0,
		ST_STORED   = 3'd1,
		ST_REJECTED = 3'd2,
		ST_PORT     = 3'd3,
		ST_NO_PORT  = 3'd4,
		ST_ERROR    = 3'd5,
		ST_NO_CALL  = 3'd6,
		ST_BAD_TYPE = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_SHORT = 2'd1,
		KIND_CALL  = 2'd2,
		KIND_REPLY = 2'd3
	} kind_t;

	// Summary of one finished payload (or a clear request), built by the front.
	typedef struct packed {
		kind_t       kind;
		logic        bad_type;
		logic [3:0]  session;
		logic        call_ok;    // call fully parsed and eligible to store
		logic        parsed;
		logic        accepted;   // accepted and successful
		logic [31:0] xid;
		logic [31:0] value;
	} job_t;

endpackage

[rtl/rpgt_front.sv]
// Front end: walks payload words through the RPC header and emits one job
// per finished payload or clear request. Uses rpgt_pkg.
module rpgt_front #(
	parameter int unsigned MAX_WORDS     = rpgt_pkg::MaxWordsDefault,
	parameter int unsigned PROGRAM_SLOTS = rpgt_pkg::SlotsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic                 opcode,
	input  logic [3:0]           session,
	input  logic [31:0]          payload_word,
	input  logic                 first_word,
	input  logic                 last_word,
	input  logic                 is_tcp,
	input  logic [31:0]          slots [rpgt_pkg::NumSlotRegs],
	output logic                 job_valid,
	output rpgt_pkg::job_t       job
);
	import rpgt_pkg::*;

	localparam int unsigned IdxW = $clog2(MAX_WORDS + 1);
	localparam int unsigned SkipW = $clog2(MAX_WORDS + 1);

	phase_t            phase_q, ph;
	logic [IdxW-1:0]   idx_q, idx;
	logic [SkipW-1:0]  skip_q, skip;
	logic [31:0]       id_q, id, val_q, val;
	logic              tcp_q, tcp, call_q, call, reply_q, reply, fail_q, fail;
	logic              cond_q, cond, acc_q, acc, succ_q, succ, done_q, done;
	logic [IdxW-1:0]   rel;
	logic              active, prog_ok;
	logic [IdxW:0]     cnt;
	logic              len_bad;
	logic [31:0]       w;

	assign w = payload_word;
	// Length field must be word aligned and fit in the counted window.
	assign len_bad = (w[1:0] != 2'b00) || (w > 32'(MAX_WORDS * 4));

	always_comb begin
		prog_ok = 1'b0;
		for (int i = 0; i < PROGRAM_SLOTS; i++)
			if (slots[i] != 32'd0 && slots[i] == val) prog_ok = 1'b1;
	end

	always_comb begin
		ph = phase_q; idx = idx_q; skip = skip_q; id = id_q; val = val_q;
		tcp = tcp_q; call = call_q; reply = reply_q; fail = fail_q;
		cond = cond_q; acc = acc_q; succ = succ_q; done = done_q;
		active = 1'b0;
		rel = '0;
		if (in_fire && !opcode) begin
			if (first_word) begin
				ph = PH_HEAD; idx = '0; skip = '0; id = '0; val = '0;
				tcp = is_tcp; call = 1'b0; reply = 1'b0; fail = 1'b0;
				cond = 1'b1; acc = 1'b0; succ = 1'b0; done = 1'b0;
			end
			active = first_word || (phase_q != PH_IDLE);
			if (active && idx < IdxW'(MAX_WORDS)) begin
				if (!(tcp && idx == '0)) begin
					rel = idx - IdxW'(tcp);
					unique case (ph)
						PH_HEAD: begin
							if (rel == '0) id = w;
							else if (w == 32'd0) begin call = 1'b1; ph = PH_CFIX; end
							else if (w == 32'd1) begin reply = 1'b1; ph = PH_RFIX; end
							else ph = PH_STOP;
						end
						PH_CFIX: begin
							if (rel == IdxW'(2) && w != RpcVers) cond = 1'b0;
							if (rel == IdxW'(3) && w != PmapProgram) cond = 1'b0;
							if (rel == IdxW'(5) && w != ProcGetport) cond = 1'b0;
							if (rel == IdxW'(7)) begin
								if (len_bad) begin fail = 1'b1; ph = PH_STOP; end
								else begin skip = SkipW'(w >> 2); ph = PH_CSKIP1; end
							end
						end
						PH_CSKIP1: begin
							if (skip != '0) skip = skip - 1'b1;
							else ph = PH_CVLEN;
						end
						PH_CVLEN: begin
							if (len_bad) begin fail = 1'b1; ph = PH_STOP; end
							else begin skip = SkipW'(w >> 2); ph = PH_CSKIP2; end
						end
						PH_CSKIP2: begin
							if (skip != '0) skip = skip - 1'b1;
							else begin val = w; done = 1'b1; ph = PH_DONE; end
						end
						PH_RFIX: begin
							if (rel == IdxW'(2) && w == 32'd0) acc = 1'b1;
							if (rel == IdxW'(4)) begin
								if (len_bad) begin fail = 1'b1; ph = PH_STOP; end
								else begin skip = SkipW'(w >> 2); ph = PH_RSKIP; end
							end
						end
						PH_RSKIP: begin
							if (skip != '0) skip = skip - 1'b1;
							else begin
								if (w == 32'd0) succ = 1'b1;
								ph = PH_RPORT;
							end
						end
						PH_RPORT: begin val = w; done = 1'b1; ph = PH_DONE; end
						default: ;
					endcase
				end
				idx = idx + 1'b1;
			end
			if (active && last_word) ph = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; idx_q <= '0; skip_q <= '0; id_q <= '0; val_q <= '0;
			tcp_q <= 1'b0; call_q <= 1'b0; reply_q <= 1'b0; fail_q <= 1'b0;
			cond_q <= 1'b0; acc_q <= 1'b0; succ_q <= 1'b0; done_q <= 1'b0;
		end else begin
			phase_q <= ph; idx_q <= idx; skip_q <= skip; id_q <= id; val_q <= val;
			tcp_q <= tcp; call_q <= call; reply_q <= reply; fail_q <= fail;
			cond_q <= cond; acc_q <= acc; succ_q <= succ; done_q <= done;
		end
	end

	// Job formed combinationally; the queue registers it.
	assign cnt = {1'b0, idx};
	always_comb begin
		job_valid = in_fire && (opcode || (active && last_word));
		job.session  = session;
		job.xid      = id;
		job.value    = val;
		job.parsed   = done && !fail;
		job.accepted = acc && succ;
		job.call_ok  = done && !fail && cond && id != 32'd0 && prog_ok;
		job.bad_type = !call && !reply;
		if (opcode) job.kind = KIND_CLEAR;
		else if (cnt < (IdxW + 1)'(MinWords)) job.kind = KIND_SHORT;
		else if (call) job.kind = KIND_CALL;
		else job.kind = KIND_REPLY;
	end
endmodule

[rtl/rpgt_queue.sv]
// Short FIFO of jobs between the front and the back end. Uses rpgt_pkg.
module rpgt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rpgt_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output rpgt_pkg::job_t head
);
	import rpgt_pkg::*;

	localparam int unsigned PtrW = $clog2(QueueDepth);

	job_t            mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0]   cnt_q;

	assign full  = cnt_q == (PtrW + 1)'(QueueDepth);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
		end
	end
endmodule

[rtl/rpgt_back.sv]
// Back end: applies jobs to the per-session call store and registers the
// result item. Uses rpgt_pkg.
module rpgt_back #(
	parameter int unsigned SESSIONS = rpgt_pkg::SessionsDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  rpgt_pkg::job_t job,
	output logic           job_ready,
	output logic           res_valid,
	input  logic           res_ready,
	output logic [3:0]     res_session,
	output logic [2:0]     res_status,
	output logic [15:0]    res_port,
	output logic           res_stop
);
	import rpgt_pkg::*;

	localparam int unsigned SesW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

	// Store slot for each of the sixteen session codes, folded at elaboration.
	function automatic logic [16*SesW-1:0] sess_map();
		logic [16*SesW-1:0] m;
		m = '0;
		for (int i = 0; i < 16; i++) m[i*SesW +: SesW] = SesW'(i % SESSIONS);
		return m;
	endfunction

	localparam logic [16*SesW-1:0] SessMap = sess_map();

	logic [31:0]       id_mem_q [SESSIONS];
	logic [SESSIONS-1:0] valid_q;
	logic [SesW-1:0]   s;
	logic              take, emit, set_v, clr_v;
	status_t           st;
	logic [15:0]       port;
	logic              stop;
	logic [31:0]       sid;

	assign s = SessMap[SesW*32'(job.session) +: SesW];
	assign sid = id_mem_q[s];
	assign job_ready = !res_valid || res_ready;
	assign take = job_valid && job_ready;

	always_comb begin
		st = ST_SHORT; port = '0; stop = 1'b0; set_v = 1'b0; clr_v = 1'b0;
		emit = 1'b1;
		case (job.kind)
			KIND_CLEAR: begin emit = 1'b0; clr_v = 1'b1; end
			KIND_SHORT: st = ST_SHORT;
			KIND_CALL: begin
				if (job.call_ok) begin set_v = 1'b1; st = ST_STORED; end
				else begin clr_v = 1'b1; st = ST_REJECTED; end
			end
			default: begin
				if (job.bad_type) st = ST_BAD_TYPE;
				else if (!valid_q[s]) st = ST_NO_CALL;
				else begin
					clr_v = 1'b1;
					if (!job.parsed || sid != job.xid) st = ST_ERROR;
					else if (!job.accepted) st = ST_NO_PORT;
					else if (job.value == 32'd0) begin st = ST_NO_PORT; stop = 1'b1; end
					else if (job.value > PortLimit) st = ST_ERROR;
					else begin st = ST_PORT; port = job.value[15:0]; stop = 1'b1; end
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take && set_v) id_mem_q[s] <= job.xid;
		if (take && emit) begin
			res_session <= job.session;
			res_status  <= st;
			res_port    <= port;
			res_stop    <= stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (take && set_v) valid_q[s] <= 1'b1;
			if (take && clr_v) valid_q[s] <= 1'b0;
			if (take && emit) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end
endmodule

[rtl/rpc_portmap_getport_tracker_top.sv]
// Top level of the portmap GETPORT tracker: configuration registers, front
// parser, job queue and back end. Uses rpgt_pkg and the rpgt_* modules.
//
// One payload word is taken per cycle. The front parses each word the cycle it
// arrives and hands a job for each payload's last word or each clear request to a
// four-entry queue; while results are taken, the back end settles one job per cycle
// against the session store and holds the result in an output register. Input
// stalls only when the queue fills because results are not being taken. A result
// passes through the queue entry and the output register after its last word.
module rpc_portmap_getport_tracker_top #(
	parameter int unsigned SESSIONS      = rpgt_pkg::SessionsDefault,
	parameter int unsigned MAX_WORDS     = rpgt_pkg::MaxWordsDefault,
	parameter int unsigned PROGRAM_SLOTS = rpgt_pkg::SlotsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // opcode, session[3:0], payload_word[31:0], first_word, is_tcp
	input  logic        s_tlast,  // last_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // result_session[3:0], status[2:0], mapped_port[15:0], stop_inspect
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rpgt_pkg::*;

	logic [31:0] slots_q [NumSlotRegs];
	logic        in_fire, fjob_valid, q_full, q_empty, b_ready;
	job_t        fjob, qhead;
	logic [3:0]  r_sess;
	logic [2:0]  r_st;
	logic [15:0] r_port;
	logic        r_stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumSlotRegs; i++) slots_q[i] <= SlotReset[i];
		end else if (cfg_we) begin
			for (int i = 0; i < NumSlotRegs; i++)
				if (cfg_index == RegSlot0 + 3'(i)) slots_q[i] <= cfg_data;
		end
	end

	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	rpgt_front #(.MAX_WORDS(MAX_WORDS), .PROGRAM_SLOTS(PROGRAM_SLOTS)) u_front (
		.clk, .arst_n, .in_fire,
		.opcode(s_tdata[0]), .session(s_tdata[4:1]), .payload_word(s_tdata[36:5]),
		.first_word(s_tdata[37]), .last_word(s_tlast), .is_tcp(s_tdata[38]),
		.slots(slots_q), .job_valid(fjob_valid), .job(fjob)
	);

	rpgt_queue u_queue (
		.clk, .arst_n, .push(fjob_valid), .push_job(fjob), .full(q_full),
		.pop(!q_empty && b_ready), .empty(q_empty), .head(qhead)
	);

	rpgt_back #(.SESSIONS(SESSIONS)) u_back (
		.clk, .arst_n, .job_valid(!q_empty), .job(qhead), .job_ready(b_ready),
		.res_valid(m_tvalid), .res_ready(m_tready), .res_session(r_sess),
		.res_status(r_st), .res_port(r_port), .res_stop(r_stop)
	);

	assign m_tdata = {r_stop, r_port, r_st, r_sess};
endmodule

[rtl/rpgt_checker.sv]
// Port-level checker for the tracker top level, attached by bind.
// Uses rpgt_pkg status codes.
module rpgt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	import rpgt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[22:7] != 16'd0 |-> m_tdata[6:4] == ST_PORT)
		else $error("port given without port status");

	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23] |-> m_tdata[6:4] == ST_PORT || m_tdata[6:4] == ST_NO_PORT)
		else $error("stop flag on wrong status");

	a_rst: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result after reset");
endmodule

bind rpc_portmap_getport_tracker_top rpgt_checker u_chk (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata
);

[tb/rpc_portmap_getport_tracker_top_tb.sv]
// Testbench for the portmap GETPORT tracker top level: drives payload words and
// clear requests, predicts every result in a behavioral model and compares.
// Depends on rpgt_pkg and rpc_portmap_getport_tracker_top.
module rpc_portmap_getport_tracker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rpgt_pkg::*;

	localparam int Sessions = 16;
	localparam int MaxWords = 64;
	localparam int NumSlots = 6;
	localparam int WatchdogLimit = 20000;

	localparam logic OP_WORD  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Parser phases of the predictor.
	typedef enum int {
		P_IDLE, P_HEAD, P_CFIX, P_CSKIP1, P_CVLEN, P_CSKIP2,
		P_RFIX, P_RSKIP, P_RPORT, P_DONE, P_STOP
	} pphase_t;

	typedef struct packed {
		logic        op;
		logic [3:0]  session;
		logic [31:0] word;
		logic        first;
		logic        last;
		logic        tcp;
	} word_item_t;

	typedef struct packed {
		logic [3:0]  session;
		status_t     status;
		logic [15:0] port;
		logic        stop;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	rpc_portmap_getport_tracker_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [31:0] slot_prog [NumSlots];
	logic [31:0] call_id [Sessions];
	logic        call_valid [Sessions];
	int unsigned word_idx;
	pphase_t     phase;
	int unsigned skip_left;
	logic [31:0] cap_id;
	logic [31:0] cap_value;
	logic        f_tcp, f_call, f_reply, f_fail, f_cond, f_acc, f_succ, f_done;

	verdict_t pending_verdicts[$];
	int       error_count;
	int       verdict_count;
	int       items_sent;
	int       idle_cycles;

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
	endtask

	function automatic bit slot_match(input logic [31:0] prog);
		for (int i = 0; i < NumSlots; i++)
			if (slot_prog[i] != 0 && slot_prog[i] == prog)
				return 1;
		return 0;
	endfunction

	function automatic void take_len(input logic [31:0] len, input pphase_t nxt);
		if (len[1:0] != 0 || len > MaxWords * 4) begin
			f_fail = 1;
			phase = P_STOP;
		end else begin
			skip_left = len >> 2;
			phase = nxt;
		end
	endfunction

	function automatic void parse_one(input int unsigned w, input logic [31:0] word);
		int unsigned base;
		int unsigned rel;
		base = f_tcp ? 1 : 0;
		if (w < base)
			return;
		rel = w - base;
		case (phase)
			P_HEAD: begin
				if (rel == 0) cap_id = word;
				else if (word == 0) begin
					f_call = 1;
					phase = P_CFIX;
				end else if (word == 1) begin
					f_reply = 1;
					phase = P_RFIX;
				end else phase = P_STOP;
			end
			P_CFIX: begin
				if (rel == 2 && word != RpcVers) f_cond = 0;
				if (rel == 3 && word != PmapProgram) f_cond = 0;
				if (rel == 5 && word != ProcGetport) f_cond = 0;
				if (rel == 7) take_len(word, P_CSKIP1);
			end
			P_CSKIP1: begin
				if (skip_left > 0) skip_left--;
				else phase = P_CVLEN;
			end
			P_CVLEN: take_len(word, P_CSKIP2);
			P_CSKIP2: begin
				if (skip_left > 0) skip_left--;
				else begin
					cap_value = word;
					f_done = 1;
					phase = P_DONE;
				end
			end
			P_RFIX: begin
				if (rel == 2 && word == 0) f_acc = 1;
				if (rel == 4) take_len(word, P_RSKIP);
			end
			P_RSKIP: begin
				if (skip_left > 0) skip_left--;
				else begin
					if (word == 0) f_succ = 1;
					phase = P_RPORT;
				end
			end
			P_RPORT: begin
				cap_value = word;
				f_done = 1;
				phase = P_DONE;
			end
			default: ;
		endcase
	endfunction

	// Advances the predictor by one accepted transfer; returns 1 with a verdict
	// when the transfer produces a result.
	function automatic bit predict_verdict(input word_item_t it, output verdict_t v);
		int s;
		bit parsed;
		s = it.session;
		v = '0;
		v.session = it.session;
		if (it.op == OP_CLEAR) begin
			call_valid[s] = 0;
			return 0;
		end
		if (it.first) begin
			phase = P_HEAD;
			word_idx = 0;
			skip_left = 0;
			cap_id = 0;
			cap_value = 0;
			{f_call, f_reply, f_fail, f_acc, f_succ, f_done} = '0;
			f_cond = 1;
			f_tcp = it.tcp;
		end else if (phase == P_IDLE) begin
			return 0;
		end
		if (word_idx < MaxWords) begin
			parse_one(word_idx, it.word);
			word_idx++;
		end
		if (!it.last)
			return 0;
		parsed = f_done && !f_fail;
		v.status = ST_SHORT;
		if (word_idx * 4 < 28) v.status = ST_SHORT;
		else if (f_call) begin
			if (parsed && f_cond && cap_id != 0 && slot_match(cap_value)) begin
				call_id[s] = cap_id;
				call_valid[s] = 1;
				v.status = ST_STORED;
			end else begin
				call_valid[s] = 0;
				v.status = ST_REJECTED;
			end
		end else if (f_reply) begin
			if (!call_valid[s]) v.status = ST_NO_CALL;
			else begin
				call_valid[s] = 0;
				if (!parsed || call_id[s] != cap_id) v.status = ST_ERROR;
				else if (!f_acc || !f_succ) v.status = ST_NO_PORT;
				else if (cap_value == 0) begin
					v.status = ST_NO_PORT;
					v.stop = 1;
				end else if (cap_value > PortLimit) v.status = ST_ERROR;
				else begin
					v.status = ST_PORT;
					v.port = cap_value[15:0];
					v.stop = 1;
				end
			end
		end else v.status = ST_BAD_TYPE;
		phase = P_IDLE;
		return 1;
	endfunction

	// Result side: random stalls, compare against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				verdict_t want;
				verdict_t got;
				got = m_tdata[23:0];
				got = {m_tdata[3:0], status_t'(m_tdata[6:4]), m_tdata[22:7], m_tdata[23]};
				verdict_count++;
				if (pending_verdicts.size() == 0) begin
					error_count++;
					$display("%0t result with nothing expected: %h", $realtime, m_tdata);
				end else begin
					want = pending_verdicts.pop_front();
					if (got.session != want.session)
						report_mismatch("session", got.session, want.session);
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.port != want.port)
						report_mismatch("port", got.port, want.port);
					if (got.stop != want.stop)
						report_mismatch("stop", got.stop, want.stop);
				end
			end
			if ($urandom_range(0, 99) < 70) m_tready <= 1'b1;
			else if ($urandom_range(0, 9) == 0) m_tready <= 1'b0;
			else m_tready <= ($urandom_range(0, 1) == 1);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_word(input word_item_t it);
		verdict_t v;
		int gap;
		gap = ($urandom_range(0, 9) < 7) ? 0 :
			(($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3));
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b0, it.tcp, it.first, it.word, it.session, it.op};
		s_tlast <= it.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (predict_verdict(it, v)) pending_verdicts.push_back(v);
		items_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_slot(input int idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx[2:0];
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		slot_prog[idx] = val;
		@(posedge clk);
	endtask

	// Builds a payload of words; random corruption makes the broken cases.
	task automatic build_message(input bit is_call, input logic [3:0] sess, input bit tcp,
			input logic [31:0] xid, input logic [31:0] value, input int damage,
			ref logic [31:0] words[$]);
		int cred;
		int verf;
		words.delete();
		cred = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
		verf = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
		if (tcp) words.push_back($urandom);
		words.push_back(xid);
		if (is_call) begin
			words.push_back(32'd0);
			words.push_back(RpcVers);
			words.push_back(PmapProgram);
			words.push_back(32'd2);
			words.push_back(ProcGetport);
			words.push_back(32'd1);
			words.push_back(cred * 4);
			repeat (cred) words.push_back($urandom);
			words.push_back(32'd0);
			words.push_back(verf * 4);
			repeat (verf) words.push_back($urandom);
			words.push_back(value);
			words.push_back(32'd2);
			words.push_back(32'd17);
			words.push_back(32'd0);
		end else begin
			words.push_back(32'd1);
			words.push_back(32'd0);
			words.push_back(32'd0);
			words.push_back(verf * 4);
			repeat (verf) words.push_back($urandom);
			words.push_back(32'd0);
			words.push_back(value);
		end
		if (damage == 1) words[$urandom_range(0, words.size() - 1)] = $urandom;
		else if (damage == 2) words[$urandom_range(0, words.size() - 1)] ^= 32'd1 << $urandom_range(0, 31);
		else if (damage == 3) repeat ($urandom_range(1, words.size() - 1)) void'(words.pop_back());
		else if (damage == 4) repeat ($urandom_range(1, 70)) words.push_back($urandom);
	endtask

	task automatic send_message(input logic [3:0] sess, input bit tcp,
			ref logic [31:0] words[$]);
		word_item_t it;
		foreach (words[i]) begin
			it.op = OP_WORD;
			it.session = sess;
			it.word = words[i];
			it.first = (i == 0);
			it.last = (i == words.size() - 1);
			it.tcp = (i == 0) ? tcp : $urandom_range(0, 1);
			send_word(it);
			// An occasional clear request in the middle of a payload.
			if ($urandom_range(0, 60) == 0) begin
				it.op = OP_CLEAR;
				it.session = $urandom;
				it.word = $urandom;
				it.first = $urandom;
				it.last = $urandom;
				send_word(it);
			end
		end
	endtask

	// Directed table: single words and short sequences with known outcomes.
	typedef struct {
		word_item_t it;
		bit         has_verdict;
		verdict_t   v;
	} table_row_t;

	initial begin
		table_row_t  rows[$];
		table_row_t  r;
		verdict_t    dv;
		logic [31:0] words[$];
		logic [31:0] xid_of [Sessions];
		logic [31:0] progs [8];
		logic [3:0]  sess;
		int          kind;
		bit          tcp;

		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		m_tready = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		verdict_count = 0;
		items_sent = 0;
		idle_cycles = 0;
		for (int i = 0; i < NumSlots; i++) slot_prog[i] = SlotReset[i];
		for (int i = 0; i < Sessions; i++) begin
			call_valid[i] = 0;
			call_id[i] = 0;
			xid_of[i] = 0;
		end
		phase = P_IDLE;
		word_idx = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: a stray word, a one-word payload, a bad message type
		// and clear requests at the extremes.
		r.has_verdict = 0;
		r.it = '{OP_WORD, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1};
		rows.push_back(r);
		r.it = '{OP_WORD, 4'd0, 32'h0, 1'b1, 1'b1, 1'b0};
		r.has_verdict = 1;
		r.v = '{4'd0, ST_SHORT, 16'd0, 1'b0};
		rows.push_back(r);
		r.has_verdict = 0;
		r.it = '{OP_CLEAR, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1};
		rows.push_back(r);
		r.it = '{OP_WORD, 4'd9, 32'h1234_5678, 1'b1, 1'b0, 1'b0};
		rows.push_back(r);
		for (int i = 0; i < 6; i++) begin
			r.it = '{OP_WORD, 4'd9, 32'd7 + i, 1'b0, (i == 5), 1'b1};
			r.has_verdict = (i == 5);
			r.v = '{4'd9, ST_BAD_TYPE, 16'd0, 1'b0};
			rows.push_back(r);
		end
		r.has_verdict = 0;
		r.it = '{OP_CLEAR, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0};
		rows.push_back(r);
		foreach (rows[i]) begin
			send_word(rows[i].it);
			if (rows[i].has_verdict) begin
				dv = pending_verdicts[$];
				if (dv != rows[i].v) report_mismatch("directed row", i, dv.status);
			end
		end

		// Directed calls and replies: port found, port zero, port too large,
		// id mismatch, reply with no call, and an over-long call with a zero id.
		build_message(1, 4'd3, 0, 32'hA5A5_0001, 32'd100003, 0, words);
		send_message(4'd3, 0, words);
		build_message(0, 4'd3, 1, 32'hA5A5_0001, 32'd65535, 0, words);
		send_message(4'd3, 1, words);
		build_message(1, 4'd4, 1, 32'h0000_0002, 32'd100000, 0, words);
		send_message(4'd4, 1, words);
		build_message(0, 4'd4, 0, 32'h0000_0002, 32'd0, 0, words);
		send_message(4'd4, 0, words);
		build_message(1, 4'd5, 0, 32'hFFFF_FFFF, 32'd100227, 0, words);
		send_message(4'd5, 0, words);
		build_message(0, 4'd5, 0, 32'hFFFF_FFFF, 32'd65536, 0, words);
		send_message(4'd5, 0, words);
		build_message(1, 4'd6, 0, 32'd9, 32'd100021, 0, words);
		send_message(4'd6, 0, words);
		build_message(0, 4'd6, 0, 32'd8, 32'd80, 0, words);
		send_message(4'd6, 0, words);
		build_message(0, 4'd7, 0, 32'd8, 32'd80, 0, words);
		send_message(4'd7, 0, words);
		build_message(1, 4'd8, 0, 32'd0, 32'd100000, 4, words);
		send_message(4'd8, 0, words);
		drain_results();

		// Random phases, each under a different slot setting.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: for (int i = 0; i < NumSlots; i++) write_slot(i, SlotReset[i]);
				1: for (int i = 0; i < NumSlots; i++) write_slot(i, 32'hFFFF_FFFF - i);
				2: for (int i = 0; i < NumSlots; i++) write_slot(i, 32'd0);
				default: for (int i = 0; i < NumSlots; i++) write_slot(i, $urandom_range(1, 4));
			endcase
			for (int i = 0; i < 8; i++)
				progs[i] = (i < NumSlots && $urandom_range(0, 3) != 0) ? slot_prog[i] : $urandom;
			progs[7] = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
			while (items_sent < 250 * (ph + 1) + 60) begin
				sess = $urandom;
				tcp = $urandom;
				kind = $urandom_range(0, 19);
				if (kind < 8) begin
					xid_of[sess] = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
					build_message(1, sess, tcp, xid_of[sess], progs[$urandom_range(0, 7)],
						($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0, words);
				end else if (kind < 16) begin
					build_message(0, sess, tcp,
						($urandom_range(0, 7) == 0) ? $urandom : xid_of[sess],
						($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 65535),
						($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0, words);
				end else begin
					words.delete();
					repeat ($urandom_range(1, 12)) words.push_back($urandom);
				end
				send_message(sess, tcp, words);
				if ($urandom_range(0, 50) == 0) drain_results();
			end
			drain_results();
		end

		$display("Run covered %0d input transfers and %0d results over four slot settings.",
			items_sent, verdict_count);
		if (error_count == 0 && pending_verdicts.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

[filelist.f]
rtl/rpgt_pkg.sv
rtl/rpgt_front.sv
rtl/rpgt_queue.sv
rtl/rpgt_back.sv
rtl/rpc_portmap_getport_tracker_top.sv
rtl/rpgt_checker.sv
tb/rpc_portmap_getport_tracker_top_tb.sv
